// ===== hw/rtl/sort_key_canonicalizer_assert.svh =====
// ----------------------------------------------------------------------------
// Sort key canonicalizer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORT_KEY_CANONICALIZER_ASSERT_SVH
`define SORT_KEY_CANONICALIZER_ASSERT_SVH

// Same-cycle implication.
`define SKC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sort key canonicalizer: same-cycle check failed");

// Next-cycle implication.
`define SKC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sort key canonicalizer: next-cycle check failed");

`endif

// ===== hw/rtl/skc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sort key canonicalizer package
// Delimiter codes, character constants, result type and decode functions.
// ----------------------------------------------------------------------------
package skc_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 16;
  localparam int unsigned DELIM_W = 3;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] CHAR_AT      = 8'h40;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Delimiter pair codes as stored on the closer stack.
  typedef enum logic [DELIM_W-1:0] {
    DELIM_BRACKET = 3'd0,
    DELIM_PAREN   = 3'd1,
    DELIM_BRACE   = 3'd2,
    DELIM_ANGLE   = 3'd3,
    DELIM_SQUOTE  = 3'd4,
    DELIM_BQUOTE  = 3'd5,
    DELIM_DQUOTE  = 3'd6
  } skc_delim_e;

  typedef struct packed {
    logic       hit;
    skc_delim_e code;
  } skc_opener_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] out_char;
    logic       key_end;
    logic       overflow;
  } skc_result_t;

  function automatic skc_opener_t opener_decode(input logic [7:0] ch);
    skc_opener_t r;
    r.hit  = 1'b1;
    r.code = DELIM_BRACKET;
    unique case (ch)
      8'h5B:   r.code = DELIM_BRACKET;
      8'h28:   r.code = DELIM_PAREN;
      8'h7B:   r.code = DELIM_BRACE;
      8'h3C:   r.code = DELIM_ANGLE;
      8'h27:   r.code = DELIM_SQUOTE;
      8'h60:   r.code = DELIM_BQUOTE;
      8'h22:   r.code = DELIM_DQUOTE;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] closer_of(input skc_delim_e code);
    logic [7:0] c;
    unique case (code)
      DELIM_BRACKET: c = 8'h5D;
      DELIM_PAREN:   c = 8'h29;
      DELIM_BRACE:   c = 8'h7D;
      DELIM_ANGLE:   c = 8'h3E;
      DELIM_SQUOTE:  c = 8'h27;
      DELIM_BQUOTE:  c = 8'h27;
      DELIM_DQUOTE:  c = 8'h22;
      default:       c = 8'h5D;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/skc_if.sv =====
// ----------------------------------------------------------------------------
// Sort key canonicalizer channel interfaces
// Valid/ready channels for key bytes, results and the mode register write.
// ----------------------------------------------------------------------------
interface skc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;
  logic       last;

  modport source (output valid, ch, first, last, input ready);
  modport sink   (input valid, ch, first, last, output ready);
endinterface

interface skc_out_if;
  logic       valid;
  logic       ready;
  logic       emit;
  logic [7:0] out_char;
  logic       key_end;
  logic       overflow;

  modport source (output valid, emit, out_char, key_end, overflow, input ready);
  modport sink   (input valid, emit, out_char, key_end, overflow, output ready);
endinterface

interface skc_cfg_if;
  logic valid;
  logic ready;
  logic markup_mode;

  modport source (output valid, markup_mode, input ready);
  modport sink   (input valid, markup_mode, output ready);
endinterface

// ===== hw/rtl/skc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/skc_core.sv =====
// ----------------------------------------------------------------------------
// Sort key canonicalizer core
// Per-byte classification, skip state and closer stack with top forwarding.
// ----------------------------------------------------------------------------
`include "sort_key_canonicalizer_assert.svh"

module skc_core #(
  parameter int unsigned STACK_DEPTH = skc_pkg::DEFAULT_STACK_DEPTH,
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1),
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                markup_mode_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [7:0]          ch_i,
  input  logic                first_i,
  input  logic                last_i,
  output logic                res_valid_o,
  output skc_pkg::skc_result_t res_o
);

  localparam logic [LW-1:0] FULL_LEVEL = LW'(STACK_DEPTH);

  logic                skip_q, skip_d;
  logic [LW-1:0]       level_q, level_d;
  logic                fwd_q, fwd_d;
  skc_pkg::skc_delim_e fwd_code_q;

  logic                in_fire;
  logic                eff_skip;
  logic [LW-1:0]       eff_level;
  logic [LW-1:0]       rd_level;
  logic [AW-1:0]       rd_addr;
  logic [skc_pkg::DELIM_W-1:0] rd_data;
  skc_pkg::skc_delim_e top_code;
  skc_pkg::skc_opener_t opener;
  logic                wr_en;
  skc_pkg::skc_result_t res;

  assign in_fire   = in_valid_i && in_ready_i;
  assign eff_skip  = first_i ? markup_mode_i : skip_q;
  assign eff_level = first_i ? '0 : level_q;
  assign opener    = skc_pkg::opener_decode(ch_i);
  // The entry written last cycle is not yet in the registered read data.
  assign top_code  = fwd_q ? fwd_code_q : skc_pkg::skc_delim_e'(rd_data);

  always_comb begin
    skip_d       = skip_q;
    level_d      = level_q;
    wr_en        = 1'b0;
    res.emit     = 1'b0;
    res.out_char = 8'h00;
    res.key_end  = last_i;
    res.overflow = 1'b0;
    if (in_fire) begin
      skip_d  = eff_skip;
      level_d = eff_level;
      if (eff_skip) begin
        if (opener.hit) begin
          skip_d = 1'b0;
          if (eff_level < FULL_LEVEL) begin
            wr_en   = 1'b1;
            level_d = eff_level + LW'(1);
          end else begin
            res.overflow = 1'b1;
          end
        end
      end else if (ch_i >= skc_pkg::CHAR_UPPER_A && ch_i <= skc_pkg::CHAR_UPPER_Z) begin
        res.emit     = 1'b1;
        res.out_char = ch_i + skc_pkg::CASE_OFFSET;
      end else if (eff_level != '0 && skc_pkg::closer_of(top_code) == ch_i) begin
        level_d = eff_level - LW'(1);
      end else if (markup_mode_i && ch_i == skc_pkg::CHAR_AT) begin
        skip_d = 1'b1;
      end else if (ch_i < skc_pkg::CHAR_SPACE) begin
        res.emit     = 1'b1;
        res.out_char = skc_pkg::CHAR_SPACE;
      end else begin
        res.emit     = 1'b1;
        res.out_char = ch_i;
      end
    end
  end

  // The read address tracks the next top of stack; a push lands on it.
  assign rd_level = level_d - LW'(1);
  assign rd_addr  = rd_level[AW-1:0];
  assign fwd_d    = wr_en;

  skc_ram #(
    .WIDTH (skc_pkg::DELIM_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (eff_level[AW-1:0]),
    .wdata_i (opener.code),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q  <= 1'b0;
      level_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      skip_q  <= skip_d;
      level_q <= level_d;
      fwd_q   <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_code_q <= opener.code;
    end
  end

  assign res_valid_o = in_fire;
  assign res_o       = res;

  `SKC_ASSERT_IMPLIES(a_level_bound, 1'b1, level_q <= FULL_LEVEL)
  `SKC_ASSERT_NEXT(a_overflow_full, in_fire && res.overflow, level_q == FULL_LEVEL)
  `SKC_ASSERT_NEXT(a_push_ends_skip, wr_en, !skip_q && level_q != '0)
  `SKC_ASSERT_IMPLIES(a_no_result_idle, !in_fire, !wr_en && level_d == level_q)

endmodule

// ===== hw/rtl/skc_out_buf.sv =====
// ----------------------------------------------------------------------------
// Sort key canonicalizer result buffer
// Output register and skid entry; under stall the core runs until both fill.
// ----------------------------------------------------------------------------
`include "sort_key_canonicalizer_assert.svh"

module skc_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  skc_pkg::skc_result_t in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output skc_pkg::skc_result_t out_data_o
);

  logic                 main_v_q, main_v_d;
  logic                 skid_v_q, skid_v_d;
  skc_pkg::skc_result_t main_q, main_d;
  skc_pkg::skc_result_t skid_q, skid_d;
  logic                 push, pop;

  assign in_ready_o = !skid_v_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = main_v_q && out_ready_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = push;
        main_d   = in_data_i;
      end
    end else if (push) begin
      if (!main_v_q) begin
        main_v_d = 1'b1;
        main_d   = in_data_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  `SKC_ASSERT_IMPLIES(a_skid_needs_main, skid_v_q, main_v_q)
  `SKC_ASSERT_NEXT(a_skid_held, skid_v_q && !out_ready_i, skid_v_q && $stable(skid_q))
  `SKC_ASSERT_NEXT(a_push_lands, push && !pop, main_v_q)

endmodule

// ===== hw/rtl/sort_key_canonicalizer.sv =====
// ----------------------------------------------------------------------------
// Sort key canonicalizer
// Folds case, maps control bytes to spaces and strips markup from sort keys.
// ----------------------------------------------------------------------------
// The block takes one key byte per request on in_i and returns exactly one
// result per byte on out_o, in order. A result is offered in the cycle after
// its byte is accepted when the result register is free; a stalled consumer
// delays it. The block sustains one byte per cycle: the closer stack sits in
// a small RAM whose registered read port holds the current top of
// stack, and an entry pushed in the previous cycle is forwarded from a
// register, so the top is ready for the very next byte. A result register
// with a skid entry lets the block keep taking bytes while the consumer
// stalls until both hold a result; input ready then drops and returns in the
// cycle after the consumer takes a result. Upper case letters come out in
// lower case, bytes below a space become a space, and bytes from 128 up pass
// unchanged. With markup_mode set, an '@' starts skipping until an opening
// delimiter, whose closer is pushed and later dropped when it matches; a
// push onto a full stack is dropped and flagged with overflow. A byte with
// first set clears the stack and starts skipping when markup mode is on. The
// mode register is written on cfg_i, always ready, and should only be
// written while no request is in flight. A new mode applies to the '@' test
// from the next byte on; skipping is only reloaded by a byte with first set.
// The stack needs no clearing after reset, since only entries below the
// current level are ever read.
// ----------------------------------------------------------------------------
module sort_key_canonicalizer #(
  parameter int unsigned STACK_DEPTH = skc_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skc_cfg_if.sink   cfg_i,
  skc_in_if.sink    in_i,
  skc_out_if.source out_o
);

  logic                 markup_q;
  logic                 res_valid;
  logic                 buf_ready;
  skc_pkg::skc_result_t res;
  skc_pkg::skc_result_t out_data;

  // Mode register; the write channel never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markup_q <= 1'b0;
    end else if (cfg_i.valid) begin
      markup_q <= cfg_i.markup_mode;
    end
  end

  // Byte classification and stack update happen in the accept cycle.
  skc_core #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .markup_mode_i (markup_q),
    .in_valid_i    (in_i.valid),
    .in_ready_i    (buf_ready),
    .ch_i          (in_i.ch),
    .first_i       (in_i.first),
    .last_i        (in_i.last),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  assign in_i.ready = buf_ready;

  // Results wait here until the consumer takes them.
  skc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (buf_ready),
    .in_data_i   (res),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

  assign out_o.emit     = out_data.emit;
  assign out_o.out_char = out_data.out_char;
  assign out_o.key_end  = out_data.key_end;
  assign out_o.overflow = out_data.overflow;

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Sort key canonicalizer testbench
// Drives key bytes through the block under random idling and back pressure,
// predicts every result with an independent model of the key folding and
// markup stripping, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned STACK_DEPTH  = skc_pkg::DEFAULT_STACK_DEPTH;
  // Covers the path from request to result, plus a little margin.
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 600000;

  // Delimiter characters.
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LANGLE = 8'h3C;
  localparam logic [7:0] CH_RANGLE = 8'h3E;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  logic clk_i = 1'b0;
  logic rst_ni;

  skc_cfg_if cfg_if ();
  skc_in_if  in_if ();
  skc_out_if out_if ();

  sort_key_canonicalizer #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Predictor state: the mode register and the key parser as the block
  // should hold them after each accepted byte. The queue holds the pending
  // closers, innermost last.
  logic                 markup_on = 1'b0;
  logic                 skip_now  = 1'b0;
  skc_pkg::skc_delim_e  closer_codes [$];

  skc_pkg::skc_result_t canon_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        holding = 1'b0;

  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned emitted      = 0;
  int unsigned overflows    = 0;
  int unsigned errors       = 0;

  // Opening or closing character of a delimiter pair.
  function automatic logic [7:0] delim_char(input int unsigned k, input bit closing);
    case (skc_pkg::skc_delim_e'(k))
      skc_pkg::DELIM_BRACKET: return closing ? CH_RBRACK : CH_LBRACK;
      skc_pkg::DELIM_PAREN:   return closing ? CH_RPAREN : CH_LPAREN;
      skc_pkg::DELIM_BRACE:   return closing ? CH_RBRACE : CH_LBRACE;
      skc_pkg::DELIM_ANGLE:   return closing ? CH_RANGLE : CH_LANGLE;
      skc_pkg::DELIM_SQUOTE:  return CH_SQUOTE;
      skc_pkg::DELIM_BQUOTE:  return closing ? CH_SQUOTE : CH_BQUOTE;
      skc_pkg::DELIM_DQUOTE:  return CH_DQUOTE;
      default:                return CH_RBRACK;
    endcase
  endfunction

  // Works out the result of one key byte and advances the parser state.
  function automatic skc_pkg::skc_result_t canonicalize(input logic [7:0] c,
                                                        input logic is_first,
                                                        input logic is_last);
    skc_pkg::skc_result_t r;
    bit                   hit;
    skc_pkg::skc_delim_e  code;
    r         = '0;
    r.key_end = is_last;
    hit       = 1'b0;
    code      = skc_pkg::DELIM_BRACKET;
    if (is_first) begin
      closer_codes.delete();
      skip_now = markup_on;
    end
    if (skip_now) begin
      for (int k = 0; k < 7; k++) begin
        if (!hit && delim_char(k, 1'b0) == c) begin
          hit  = 1'b1;
          code = skc_pkg::skc_delim_e'(k);
        end
      end
      if (hit) begin
        if (closer_codes.size() < STACK_DEPTH) begin
          closer_codes.push_back(code);
        end else begin
          r.overflow = 1'b1;
        end
        skip_now = 1'b0;
      end
    end else if (c >= skc_pkg::CHAR_UPPER_A && c <= skc_pkg::CHAR_UPPER_Z) begin
      r.emit     = 1'b1;
      r.out_char = c + skc_pkg::CASE_OFFSET;
    end else if (closer_codes.size() != 0 &&
                 delim_char(int'(closer_codes[$]), 1'b1) == c) begin
      void'(closer_codes.pop_back());
    end else if (markup_on && c == skc_pkg::CHAR_AT) begin
      skip_now = 1'b1;
    end else if (c < skc_pkg::CHAR_SPACE) begin
      r.emit     = 1'b1;
      r.out_char = skc_pkg::CHAR_SPACE;
    end else begin
      r.emit     = 1'b1;
      r.out_char = c;
    end
    return r;
  endfunction

  // Random byte weighted toward the characters that steer the parser.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0, 1:    return 8'($urandom_range(255, 1));
      2:       return skc_pkg::CHAR_UPPER_A + 8'($urandom_range(25));
      3:       return CHAR_LOWER_A + 8'($urandom_range(25));
      4:       return 8'($urandom_range(31, 1));
      5:       return 8'($urandom_range(255, 128));
      6:       return delim_char($urandom_range(6), 1'b0);
      7, 8:    return delim_char($urandom_range(6), 1'b1);
      9:       return skc_pkg::CHAR_AT;
      10:      return skc_pkg::CHAR_SPACE;
      default: return 8'h7F;
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  // Result side: checks every accepted result against the oldest prediction
  // and decides ready for the next cycle.
  always @(posedge clk_i) begin
    skc_pkg::skc_result_t got;
    skc_pkg::skc_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.emit     = out_if.emit;
      got.out_char = out_if.out_char;
      got.key_end  = out_if.key_end;
      got.overflow = out_if.overflow;
      results_seen++;
      if (canon_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, got 0x%0h", $time, got);
      end else begin
        want = canon_q.pop_front();
        if (want.emit) emitted++;
        if (want.overflow) overflows++;
        if (got.emit !== want.emit) begin
          report_mismatch("emit", 8'(want.emit), 8'(got.emit));
        end
        if (got.out_char !== want.out_char) begin
          report_mismatch("out_char", want.out_char, got.out_char);
        end
        if (got.key_end !== want.key_end) begin
          report_mismatch("key_end", 8'(want.key_end), 8'(got.key_end));
        end
        if (got.overflow !== want.overflow) begin
          report_mismatch("overflow", 8'(want.overflow), 8'(got.overflow));
        end
      end
    end
    out_if.ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offers one byte, waits for the request to be taken and records the
  // predicted result. Valid stays high if the next byte follows at once.
  task automatic send_byte(input logic [7:0] c, input logic is_first, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    in_if.first <= is_first;
    in_if.last  <= is_last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    canon_q.push_back(canonicalize(c, is_first, is_last));
    items_sent++;
  endtask

  // Stops offering bytes and waits until every predicted result has arrived.
  task automatic quiesce();
    in_if.valid <= 1'b0;
    while (canon_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes the mode register; only called while the block is idle.
  task automatic write_mode(input logic m);
    cfg_if.valid       <= 1'b1;
    cfg_if.markup_mode <= m;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    markup_on = m;
  endtask

  task automatic hold_receiver(input int unsigned n);
    holding <= 1'b1;
    repeat (n) @(posedge clk_i);
    holding <= 1'b0;
  endtask

  // Builds one key and sends it. Most keys are well formed: leading junk,
  // an opener, then text mixed with nested directives and their closers.
  // The rest are deep nests that may run past the stack, random bytes, and
  // loose bytes with random first and last markers.
  task automatic send_random_key();
    logic [7:0]  key_q [$];
    int unsigned open_q [$];
    int unsigned kind;
    int unsigned k;
    bit          loose;
    kind  = $urandom_range(99);
    loose = 1'b0;
    if (kind < 65) begin
      repeat ($urandom_range(3)) begin
        key_q.push_back(skc_pkg::CHAR_UPPER_A + 8'($urandom_range(25)));
      end
      k = $urandom_range(6);
      key_q.push_back(delim_char(k, 1'b0));
      open_q.push_back(k);
      repeat ($urandom_range(6, 1)) begin
        case ($urandom_range(2))
          0: repeat ($urandom_range(4, 1)) key_q.push_back(pick_byte());
          1: begin
            key_q.push_back(skc_pkg::CHAR_AT);
            repeat ($urandom_range(2)) begin
              key_q.push_back(skc_pkg::CHAR_UPPER_A + 8'($urandom_range(25)));
            end
            k = $urandom_range(6);
            key_q.push_back(delim_char(k, 1'b0));
            open_q.push_back(k);
          end
          default: begin
            if (open_q.size() != 0) key_q.push_back(delim_char(open_q.pop_back(), 1'b1));
          end
        endcase
      end
      while (open_q.size() != 0 && $urandom_range(9) != 0) begin
        key_q.push_back(delim_char(open_q.pop_back(), 1'b1));
      end
    end else if (kind < 78) begin
      // Nest deep enough to hit the stack limit about half the time.
      k = $urandom_range(6);
      key_q.push_back(delim_char(k, 1'b0));
      open_q.push_back(k);
      repeat ($urandom_range(STACK_DEPTH + 4, STACK_DEPTH - 6)) begin
        k = $urandom_range(6);
        key_q.push_back(skc_pkg::CHAR_AT);
        key_q.push_back(delim_char(k, 1'b0));
        open_q.push_back(k);
      end
      repeat ($urandom_range(3)) key_q.push_back(pick_byte());
      while (open_q.size() != 0 && $urandom_range(7) != 0) begin
        key_q.push_back(delim_char(open_q.pop_back(), 1'b1));
      end
    end else if (kind < 90) begin
      repeat ($urandom_range(10, 1)) key_q.push_back(pick_byte());
    end else begin
      loose = 1'b1;
      repeat ($urandom_range(6, 1)) key_q.push_back(pick_byte());
    end
    for (int i = 0; i < key_q.size(); i++) begin
      if (loose) begin
        send_byte(key_q[i], i != 0 && $urandom_range(9) == 0, $urandom_range(3) == 0);
      end else begin
        send_byte(key_q[i], i == 0, i == key_q.size() - 1);
      end
    end
  endtask

  // Plain mode: folding, control bytes, high bytes, the zero byte, and a
  // closer that finds nothing to pop. The first byte carries no first
  // marker, so it runs on the state left by reset.
  task automatic test_plain_bytes();
    write_mode(1'b0);
    send_byte(skc_pkg::CHAR_UPPER_A, 1'b0, 1'b0);
    send_byte(skc_pkg::CHAR_UPPER_Z, 1'b0, 1'b0);
    send_byte(CHAR_LOWER_A, 1'b0, 1'b0);
    send_byte(skc_pkg::CHAR_AT, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h1F, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hC1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(CH_RBRACK, 1'b1, 1'b0);
    send_byte(8'h01, 1'b1, 1'b1);
    quiesce();
  endtask

  // Markup mode: the key opens in skipping state, directives push and pop,
  // a zero byte is dropped while skipping, and the back quote pair closes
  // on a single quote. The key is left open with a pending brace and an
  // active skip for the next test.
  task automatic test_markup_directives();
    write_mode(1'b1);
    send_byte(8'h78, 1'b1, 1'b0);
    send_byte(CH_DQUOTE, 1'b0, 1'b0);
    send_byte(8'h42, 1'b0, 1'b0);
    send_byte(CH_DQUOTE, 1'b0, 1'b0);
    send_byte(skc_pkg::CHAR_AT, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h51, 1'b0, 1'b0);
    send_byte(CH_BQUOTE, 1'b0, 1'b0);
    send_byte(CH_SQUOTE, 1'b0, 1'b0);
    send_byte(CH_RPAREN, 1'b0, 1'b0);
    send_byte(skc_pkg::CHAR_AT, 1'b0, 1'b0);
    send_byte(CH_LBRACE, 1'b0, 1'b0);
    send_byte(skc_pkg::CHAR_AT, 1'b0, 1'b1);
    quiesce();
  endtask

  // Mode turned off without a new key: the skip and the stack carry on,
  // closers still pop, and an '@' is now an ordinary byte.
  task automatic test_mode_carry_over();
    write_mode(1'b0);
    send_byte(8'h58, 1'b0, 1'b0);
    send_byte(CH_LANGLE, 1'b0, 1'b0);
    send_byte(8'h6B, 1'b0, 1'b0);
    send_byte(CH_RANGLE, 1'b0, 1'b0);
    send_byte(skc_pkg::CHAR_AT, 1'b0, 1'b0);
    send_byte(CH_RBRACE, 1'b0, 1'b0);
    send_byte(CH_RBRACE, 1'b0, 1'b1);
    quiesce();
  endtask

  // Fill the stack, then push twice more: both pushes are dropped and
  // flagged, and skipping still ends each time.
  task automatic test_stack_overflow();
    write_mode(1'b1);
    send_byte(CH_LPAREN, 1'b1, 1'b0);
    repeat (STACK_DEPTH - 1) begin
      send_byte(skc_pkg::CHAR_AT, 1'b0, 1'b0);
      send_byte(CH_LBRACK, 1'b0, 1'b0);
    end
    send_byte(skc_pkg::CHAR_AT, 1'b0, 1'b0);
    send_byte(CH_LBRACE, 1'b0, 1'b0);
    send_byte(CHAR_LOWER_A, 1'b0, 1'b0);
    send_byte(skc_pkg::CHAR_AT, 1'b0, 1'b0);
    send_byte(CH_LANGLE, 1'b0, 1'b0);
    send_byte(CH_RBRACK, 1'b0, 1'b0);
    send_byte(CH_RBRACE, 1'b0, 1'b1);
    quiesce();
  endtask

  task automatic test_random_keys(input logic mode, input int unsigned s_idle,
                                  input int unsigned r_idle, input int unsigned n_items);
    int unsigned stop_at;
    write_mode(mode);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_key();
    quiesce();
  endtask

  // The receiver stops for a long stretch while the sender keeps offering,
  // so the block fills its result stage and has to stall its input.
  task automatic test_back_pressure();
    int unsigned stop_at;
    write_mode(1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stop_at = items_sent + 80;
    fork
      hold_receiver(HOLD_CYCLES);
      while (items_sent < stop_at) send_random_key();
    join
    quiesce();
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.ch           = 8'h00;
    in_if.first        = 1'b0;
    in_if.last         = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.markup_mode = 1'b0;
    out_if.ready       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 35;
    recv_idle_pct = 85;
    test_plain_bytes();
    test_markup_directives();
    test_mode_carry_over();
    test_stack_overflow();
    test_random_keys(1'b1, 35, 85, 400);
    test_random_keys(1'b0, 85, 35, 300);
    test_random_keys(1'b1, 0, 0, 400);
    test_back_pressure();

    $display("Sent %0d key bytes in plain and markup mode under three idle patterns",
             items_sent);
    $display("and a long consumer stall: %0d results, %0d emitted, %0d overflows, %0d errors.",
             results_seen, emitted, overflows, errors);
    if (errors == 0) begin
      $display("sort_key_canonicalizer test passed");
    end else begin
      $display("sort_key_canonicalizer test failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("sort_key_canonicalizer test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/skc_pkg.sv
hw/rtl/skc_if.sv
hw/rtl/skc_ram.sv
hw/rtl/skc_core.sv
hw/rtl/skc_out_buf.sv
hw/rtl/sort_key_canonicalizer.sv
sim/testbench.sv
